[rtl/biv_pkg.sv]
// shared types, constants and codes for the boot image verifier
package biv_pkg;

   localparam logic [31:0] HEADER_BYTES = 32'd64;
   localparam logic [31:0] IMAGE_MAGIC  = 32'h4F54_4158;
   localparam logic [31:0] ALL_ONES     = 32'hFFFF_FFFF;
   localparam logic [31:0] THUMB_MASK   = 32'hFFFF_FFFE;
   localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;

   // csr register indexes
   localparam logic [1:0] CSR_REGION_SIZE = 2'd0;
   localparam logic [1:0] CSR_RUN_BASE    = 2'd1;
   localparam logic [1:0] CSR_RUN_SIZE    = 2'd2;

   // request kinds
   localparam logic MODE_HEADER  = 1'b0;
   localparam logic MODE_PAYLOAD = 1'b1;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_MAGIC  = 3'd1,
      ST_LENGTH = 3'd2,
      ST_CRC    = 3'd3,
      ST_VECTOR = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'b01,
      PH_PAYLOAD = 2'b10
   } phase_type;

   typedef struct packed {
      logic        mode;
      logic [31:0] magic_word;
      logic [31:0] payload_length;
      logic [31:0] stored_crc;
      logic [7:0]  data_byte;
   } req_data_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] image_crc;
   } rsp_data_type;

endpackage

[rtl/biv_crc_byte.sv]
// byte-wide reflected crc-32 update
module biv_crc_byte
   import biv_pkg::*;
(
   input  logic [31:0] crc_cur,
   input  logic [7:0]  data_byte,
   output logic [31:0] crc_next
);

   always_comb begin
      logic [31:0] c;
      c = crc_cur ^ {24'd0, data_byte};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_next = c;
   end

endmodule

[rtl/boot_image_verifier_unit.sv]
// top level of the boot image verifier: header checks, payload crc and reset vector window check
//
//   channel | dir | handshake            | payload
//   --------+-----+----------------------+---------------------------------------------
//   req_    | in  | req_valid/req_ready  | req_data: mode, magic, length, crc, byte
//   rsp_    | out | rsp_valid/rsp_ready  | rsp_data: status, image_crc
//   csr_    | in  | csr_valid/csr_ready  | csr_index (0 region, 1 base, 2 size), csr_data
//
// one request per cycle while req_ready is high; a result appears in the output register the cycle after the
// request that causes it (header failure or last payload byte)
// the byte-wide crc update plus the length compare sit in the single accept cycle
// reset is synchronous; it resets the csr registers (entry to the header size), the image state and the output valid
// req_ready drops only while a result is held and rsp_ready is low; csr_ready is always high
module boot_image_verifier_unit
   import biv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,

   input  logic         req_valid,
   output logic         req_ready,
   input  req_data_type req_data,

   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_data_type rsp_data,

   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   // configuration, kept in the form the checks use
   logic [31:0] base_ff, base_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] space_ff, space_in;   // region size less the header, saturated at zero
   logic [31:0] entry_ff, entry_in;   // base + header size, wraps
   logic [31:0] end_ff, end_in;       // base + window size, wraps

   // image state
   phase_type   phase_ff, phase_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] exp_crc_ff, exp_crc_in;
   logic [31:0] vector_ff, vector_in;

   // output register
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_data_type rsp_data_ff, rsp_data_in;

   logic        accept;
   logic [31:0] crc_step;
   logic [31:0] final_crc;
   logic [31:0] count_next;
   logic [31:0] vector_next;
   logic [31:0] vector_pc;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   biv_crc_byte u_crc (
      .crc_cur   (crc_ff),
      .data_byte (req_data.data_byte),
      .crc_next  (crc_step)
   );

   // csr writes precompute the window bounds and payload space
   always_comb begin
      base_in  = base_ff;
      size_in  = size_ff;
      space_in = space_ff;
      entry_in = entry_ff;
      end_in   = end_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REGION_SIZE: begin
               space_in = (csr_data > HEADER_BYTES) ? csr_data - HEADER_BYTES : 32'd0;
            end
            CSR_RUN_BASE: begin
               base_in  = csr_data;
               entry_in = csr_data + HEADER_BYTES;
               end_in   = csr_data + size_ff;
            end
            CSR_RUN_SIZE: begin
               size_in = csr_data;
               end_in  = base_ff + csr_data;
            end
            default: begin
               // writes beyond the register list are dropped
            end
         endcase
      end
   end

   // payload byte datapath
   always_comb begin
      count_next  = count_ff + 32'd1;
      final_crc   = crc_step ^ ALL_ONES;
      vector_next = vector_ff;
      // bytes 4 to 7 form the little-endian reset vector
      if (count_ff[31:2] == 30'd1) begin
         case (count_ff[1:0])
            2'd0:    vector_next[7:0]   = req_data.data_byte;
            2'd1:    vector_next[15:8]  = req_data.data_byte;
            2'd2:    vector_next[23:16] = req_data.data_byte;
            default: vector_next[31:24] = req_data.data_byte;
         endcase
      end
      vector_pc = vector_next & THUMB_MASK;
   end

   // request handling
   always_comb begin
      phase_in     = phase_ff;
      crc_in       = crc_ff;
      count_in     = count_ff;
      length_in    = length_ff;
      exp_crc_in   = exp_crc_ff;
      vector_in    = vector_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      if (accept) begin
         if (req_data.mode == MODE_HEADER) begin
            // a header always restarts, aborting any image in progress
            crc_in     = ALL_ONES;
            count_in   = 32'd0;
            vector_in  = 32'd0;
            length_in  = req_data.payload_length;
            exp_crc_in = req_data.stored_crc;
            phase_in   = PH_IDLE;
            if (req_data.magic_word != IMAGE_MAGIC) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = ST_MAGIC;
               rsp_data_in.image_crc = 32'd0;
            end else if (req_data.payload_length == 32'd0 ||
                         req_data.payload_length > space_ff) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.status    = ST_LENGTH;
               rsp_data_in.image_crc = 32'd0;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end else if (phase_ff == PH_PAYLOAD) begin
            crc_in    = crc_step;
            count_in  = count_next;
            vector_in = vector_next;
            if (!(count_next < length_ff)) begin
               // last byte: crc first, then the vector
               phase_in              = PH_IDLE;
               rsp_valid_in          = 1'b1;
               rsp_data_in.image_crc = final_crc;
               if (final_crc != exp_crc_ff) begin
                  rsp_data_in.status = ST_CRC;
               end else if (length_ff < 32'd8) begin
                  rsp_data_in.status = ST_VECTOR;
               end else if (vector_pc < entry_ff || !(vector_pc < end_ff)) begin
                  rsp_data_in.status = ST_VECTOR;
               end else begin
                  rsp_data_in.status = ST_OK;
               end
            end
         end
         // payload bytes while idle are dropped
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= 32'd0;
         size_ff      <= 32'd0;
         space_ff     <= 32'd0;
         entry_ff     <= HEADER_BYTES;
         end_ff       <= 32'd0;
         phase_ff     <= PH_IDLE;
         crc_ff       <= ALL_ONES;
         count_ff     <= 32'd0;
         length_ff    <= 32'd0;
         exp_crc_ff   <= 32'd0;
         vector_ff    <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         base_ff      <= base_in;
         size_ff      <= size_in;
         space_ff     <= space_in;
         entry_ff     <= entry_in;
         end_ff       <= end_in;
         phase_ff     <= phase_in;
         crc_ff       <= crc_in;
         count_ff     <= count_in;
         length_ff    <= length_in;
         exp_crc_ff   <= exp_crc_in;
         vector_ff    <= vector_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

endmodule

[tb/testbench.sv]
// testbench for the boot image verifier: directed and random images checked against a local model
`timescale 1ns / 100ps

import biv_pkg::*;

// one byte of the reflected crc-32, lsb first
function automatic logic [31:0] crc_next(input logic [31:0] crc, input logic [7:0] b);
   logic [31:0] c;
   c = crc ^ {24'd0, b};
   for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
   end
   return c;
endfunction

// predicts the verdict of each image and holds verdicts not yet returned
class image_verdicts;
   logic [31:0]  region_size;
   logic [31:0]  window_base;
   logic [31:0]  window_size;
   logic [31:0]  crc_run;
   logic [31:0]  bytes_taken;
   logic [31:0]  want_length;
   logic [31:0]  want_crc;
   logic [31:0]  vector_bits;
   bit           receiving;
   rsp_data_type pending_verdicts[$];
   int unsigned  failures;

   function new();
      region_size = '0;
      window_base = '0;
      window_size = '0;
      crc_run     = ALL_ONES;
      bytes_taken = '0;
      want_length = '0;
      want_crc    = '0;
      vector_bits = '0;
      receiving   = 1'b0;
      failures    = 0;
   endfunction

   function void set_register(input logic [1:0] idx, input logic [31:0] value);
      case (idx)
         CSR_REGION_SIZE: region_size = value;
         CSR_RUN_BASE:    window_base = value;
         CSR_RUN_SIZE:    window_size = value;
         default: ;
      endcase
   endfunction

   function void note_request(input req_data_type item);
      logic [31:0]  space;
      logic [31:0]  final_crc;
      logic [31:0]  entry;
      logic [31:0]  stop;
      logic [31:0]  pc;
      rsp_data_type verdict;
      if (item.mode == MODE_HEADER) begin
         // any header restarts the image, even one in progress
         crc_run     = ALL_ONES;
         bytes_taken = '0;
         vector_bits = '0;
         want_length = item.payload_length;
         want_crc    = item.stored_crc;
         receiving   = 1'b0;
         space = (region_size > HEADER_BYTES) ? region_size - HEADER_BYTES : '0;
         verdict.image_crc = '0;
         if (item.magic_word != IMAGE_MAGIC) begin
            verdict.status = ST_MAGIC;
            pending_verdicts.push_back(verdict);
         end else if (item.payload_length == '0 || item.payload_length > space) begin
            verdict.status = ST_LENGTH;
            pending_verdicts.push_back(verdict);
         end else begin
            receiving = 1'b1;
         end
      end else if (receiving) begin
         crc_run = crc_next(crc_run, item.data_byte);
         if (bytes_taken >= 4 && bytes_taken < 8)
            vector_bits |= {24'd0, item.data_byte} << (8 * (bytes_taken - 4));
         bytes_taken++;
         if (bytes_taken >= want_length) begin
            final_crc = crc_run ^ ALL_ONES;
            entry     = window_base + HEADER_BYTES;
            stop      = window_base + window_size;
            pc        = vector_bits & THUMB_MASK;
            if (final_crc != want_crc)
               verdict.status = ST_CRC;
            else if (want_length < 8)
               verdict.status = ST_VECTOR;
            else if (pc < entry || pc >= stop)
               verdict.status = ST_VECTOR;
            else
               verdict.status = ST_OK;
            verdict.image_crc = final_crc;
            receiving = 1'b0;
            pending_verdicts.push_back(verdict);
         end
      end
   endfunction

   function void check_result(input rsp_data_type got);
      rsp_data_type want;
      if (pending_verdicts.size() == 0) begin
         $error("unexpected result: status %0d image_crc %h", got.status, got.image_crc);
         failures++;
         return;
      end
      want = pending_verdicts.pop_front();
      if (got.status !== want.status) begin
         $error("status: expected %0d, actual %0d", want.status, got.status);
         failures++;
      end
      if (got.image_crc !== want.image_crc) begin
         $error("image_crc: expected %h, actual %h", want.image_crc, got.image_crc);
         failures++;
      end
   endfunction
endclass

module testbench;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_data_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [31:0]  csr_data;

   image_verdicts board;

   // current register values, used to aim vectors and lengths
   logic [31:0]  cur_region;
   logic [31:0]  cur_base;
   logic [31:0]  cur_span;

   // when set, neither side inserts idle cycles
   bit           steady;

   boot_image_verifier_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // idle cycles before the next request or the next result
   function automatic int unsigned draw_gap();
      return steady ? 0 : $urandom_range(0, 4);
   endfunction

   // header request; the unused byte field carries noise
   function automatic req_data_type header_item(input logic [31:0] magic, input logic [31:0] len,
                                                input logic [31:0] crc);
      req_data_type item;
      item.mode           = MODE_HEADER;
      item.magic_word     = magic;
      item.payload_length = len;
      item.stored_crc     = crc;
      item.data_byte      = 8'($urandom);
      return item;
   endfunction

   // payload request; the unused header fields carry noise
   function automatic req_data_type byte_item(input logic [7:0] b);
      req_data_type item;
      item.mode           = MODE_PAYLOAD;
      item.magic_word     = $urandom;
      item.payload_length = $urandom;
      item.stored_crc     = $urandom;
      item.data_byte      = b;
      return item;
   endfunction

   // mostly short images, now and then the longest the region allows (or 25 to 80 bytes if over 200)
   function automatic logic [31:0] pick_length(input logic [31:0] space);
      logic [31:0] cap;
      cap = (space < 24) ? space : 32'd24;
      if ($urandom_range(0, 11) == 0)
         return (space <= 200) ? space : $urandom_range(25, 80);
      return $urandom_range(1, cap);
   endfunction

   // reset vectors around both window bounds, plus some inside and some anywhere
   function automatic logic [31:0] pick_vector();
      logic [31:0] entry;
      logic [31:0] stop;
      entry = cur_base + HEADER_BYTES;
      stop  = cur_base + cur_span;
      case ($urandom_range(0, 7))
         0: return entry;
         1: return entry | 32'd1;
         2: return stop - 32'd1;
         3: return stop - 32'd2;
         4: return stop;
         5: return entry - 32'd1;
         6: return $urandom;
         default: return (stop > entry) ? entry + ($urandom % (stop - entry)) : $urandom;
      endcase
   endfunction

   // one request: optional idle cycles, then hold valid until the block takes it
   task automatic send_request(input req_data_type item);
      int unsigned gap;
      gap = draw_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      board.note_request(item);
   endtask

   // header plus payload; bytes 4 to 7 hold the vector, the crc may be corrupted,
   // and only the first cut bytes are sent
   task automatic send_image(input logic [31:0] length, input logic [31:0] vector,
                             input bit corrupt, input logic [31:0] cut);
      logic [7:0]  body[$];
      logic [7:0]  b;
      logic [31:0] crc;
      crc = ALL_ONES;
      for (int unsigned i = 0; i < length; i++) begin
         b = 8'($urandom);
         if (i >= 4 && i < 8)
            b = vector[8 * (i - 4) +: 8];
         body.push_back(b);
         crc = crc_next(crc, b);
      end
      crc ^= ALL_ONES;
      if (corrupt)
         crc ^= 32'd1 << $urandom_range(0, 31);
      send_request(header_item(IMAGE_MAGIC, length, crc));
      for (int unsigned i = 0; i < length && i < cut; i++)
         send_request(byte_item(body[i]));
   endtask

   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_register(idx, value);
   endtask

   // only called while the block is idle
   task automatic write_settings(input logic [31:0] region, input logic [31:0] base,
                                 input logic [31:0] span);
      write_register(CSR_REGION_SIZE, region);
      write_register(CSR_RUN_BASE, base);
      write_register(CSR_RUN_SIZE, span);
      csr_valid <= 1'b0;
      cur_region = region;
      cur_base   = base;
      cur_span   = span;
   endtask

   // stop sending, let every verdict come back, then leave the block idle before going on
   task automatic settle();
      req_valid <= 1'b0;
      while (board.pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // random traffic under one register setting, ending with a complete image (a bad-magic header if no space)
   task automatic run_phase(input int unsigned quota);
      int unsigned taken;
      int unsigned pick;
      logic [31:0] space;
      logic [31:0] len;
      logic [31:0] cut;
      space = (cur_region > HEADER_BYTES) ? cur_region - HEADER_BYTES : '0;
      taken = 0;
      while (taken < quota) begin
         pick = $urandom_range(0, 99);
         if (space != 0 && pick < 70) begin
            // well-formed image, crc wrong about one time in four
            len = pick_length(space);
            send_image(len, pick_vector(), $urandom_range(0, 3) == 0, len);
            taken += len + 1;
         end else if (pick < 80) begin
            // wrong magic
            send_request(header_item($urandom, $urandom, $urandom));
            taken++;
         end else if (pick < 88) begin
            // good magic, length around the limits
            case ($urandom_range(0, 4))
               0: len = '0;
               1: len = space + 32'd1;
               2: len = 32'd1;
               3: len = ALL_ONES;
               default: len = $urandom;
            endcase
            send_request(header_item(IMAGE_MAGIC, len, $urandom));
            taken++;
         end else if (space != 0 && pick < 95) begin
            // image cut short; the next header abandons it
            len = pick_length(space);
            cut = $urandom_range(0, len - 1);
            send_image(len, pick_vector(), 1'b0, cut);
            taken += cut + 1;
         end else begin
            // loose payload bytes, mostly ignored while idle
            repeat ($urandom_range(1, 3)) send_request(byte_item(8'($urandom)));
         end
      end
      if (space != 0) begin
         len = pick_length(space);
         send_image(len, pick_vector(), 1'b0, len);
      end else begin
         send_request(header_item(~IMAGE_MAGIC, $urandom, $urandom));
      end
   endtask

   // result side: random stall before each result, sometimes none at all
   initial begin : result_sink
      int unsigned stall;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         stall = draw_gap();
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
      end
   end

   // every accepted result goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready)
         board.check_result(rsp_data);
   end

   initial begin : stimulus
      board     = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      csr_valid = 1'b0;
      csr_index = CSR_REGION_SIZE;
      csr_data  = '0;
      steady    = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: 16 bytes of payload space, window 0x2000_0000 .. +0x1000
      write_settings(32'd80, 32'h2000_0000, 32'h0000_1000);
      send_request(byte_item(8'hFF));                              // byte with no image open
      send_request(header_item(ALL_ONES, ALL_ONES, ALL_ONES));     // bad magic, fields all ones
      send_request(header_item('0, '0, '0));                       // bad magic, fields all zero
      send_request(header_item(IMAGE_MAGIC, '0, '0));              // zero length
      send_request(header_item(IMAGE_MAGIC, 32'd17, ALL_ONES));    // one past the region space
      send_image(32'd8, 32'h2000_0041, 1'b0, 32'd2);               // abandoned by the next header
      send_image(32'd8, 32'h2000_0041, 1'b0, 32'd8);               // vector at entry, thumb bit set
      send_image(32'd3, 32'h2000_0100, 1'b0, 32'd3);               // too short for a vector
      send_image(32'd1, 32'h0000_0000, 1'b1, 32'd1);               // crc mismatch
      settle();

      // register settings from the extremes to random ones
      for (int p = 0; p < 13; p++) begin
         case (p)
            0: write_settings(32'd0, 32'd0, 32'd0);                       // no space at all
            1: write_settings(32'd63, 32'h0000_1000, 32'h0000_2000);      // region below header
            2: write_settings(32'd64, 32'h0000_1000, 32'h0000_0080);      // exactly the header
            3: write_settings(32'd65, 32'hFFFF_FFF0, 32'h0000_0100);      // window wraps
            4: write_settings(ALL_ONES, 32'd0, ALL_ONES);                 // everything maximal
            5: write_settings(32'd96, ALL_ONES, 32'd0);                   // empty window, entry wraps
            6: write_settings(32'h0000_1000, 32'h0800_0000, 32'h0004_0000);
            default: write_settings(32'd65 + $urandom_range(0, 299), $urandom,
                                    $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h2_0000));
         endcase
         steady = (p % 4 == 3);
         run_phase((p < 2) ? 20 : ((p < 7) ? 60 : 45));
         settle();
      end

      if (board.failures == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[filelist.f]
rtl/biv_pkg.sv
rtl/biv_crc_byte.sv
rtl/boot_image_verifier_unit.sv
tb/testbench.sv
